// ===== rtl/core/bilinear_bayer_demosaic_assert.svh =====
// Assertion macros for the demosaic core.
// BBD_ASSERT checks a condition on every rising clock edge outside reset.
// BBD_ASSERT_IMPL checks that an antecedent implies a consequent in the same cycle.
`ifndef BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH
`define BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH

`ifndef SYNTHESIS

`define BBD_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

`define BBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define BBD_ASSERT(lbl, clk, rst_n, cond, msg)

`define BBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/bbd_pkg.sv =====
package bbd_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_HEIGHT = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd256;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd256;

    typedef logic [PIX_W-1:0] pixel_t;

    // Position flags of one sample, carried from accept to the emitter
    typedef struct packed {
        logic row_end;     // last column of a row
        logic frame_last;  // last row of the frame
        logic has_out;     // row >= 1 and column >= 1
        logic c0;          // column parity
        logic r0;          // row parity
        logic c_is1;       // column == 1 (output column 0, left mirror)
        logic r_is1;       // row == 1 (output row 0, top mirror)
    } pos_flags_t;

endpackage

// ===== rtl/core/bilinear_bayer_demosaic.sv =====
// Path: a sample passes the stage 1 register, the emitter register and the output register.
// Throughput: one sample per cycle while the output is ready; a sample with several pixels
// holds the input until they are sent: 2 at a row end or on the last row, 4 for the last sample of a frame.
// Line buffer: one read per cycle at accept, write-back as the sample leaves stage 1.
// Reset: frame size returns to 256x256, counters, window and handshake state clear;
// the line buffer is not cleared and needs no clearing pass.
module bilinear_bayer_demosaic #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]      cfg_wdata,
    // Raw sample input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbd_pkg::PIX_W-1:0]      s_raw_sample,
    // RGB pixel output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbd_pkg::PIX_W-1:0]      m_red,
    output logic [bbd_pkg::PIX_W-1:0]      m_green,
    output logic [bbd_pkg::PIX_W-1:0]      m_blue,
    output logic                           m_last_of_run,
    output logic                           m_frame_end
);

    import bbd_pkg::*;

`include "bilinear_bayer_demosaic_assert.svh"

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam logic [EW-1:0] MAXW_E = EW'(MAX_WIDTH);

    // Configuration registers
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective frame size, clamped
    logic [EW-1:0]    fw_e;
    logic [EW-1:0]    wlast_e;
    logic [CFG_W-1:0] hlast;

    always_comb begin
        fw_e = EW'(frame_width_reg);
        if (fw_e < EW'(3)) begin
            wlast_e = EW'(2);
        end else if (fw_e > MAXW_E) begin
            wlast_e = MAXW_E - EW'(1);
        end else begin
            wlast_e = fw_e - EW'(1);
        end
        if (frame_height_reg < CFG_W'(3)) begin
            hlast = CFG_W'(2);
        end else if (frame_height_reg > CFG_W'(MAX_HEIGHT)) begin
            hlast = CFG_W'(MAX_HEIGHT - 1);
        end else begin
            hlast = frame_height_reg - CFG_W'(1);
        end
    end

    // Pipeline handshake signals
    logic s_fire;
    logic s1_valid_reg, s1_valid_next;
    logic s1_fire;
    logic em_valid_reg, em_valid_next;
    logic em_fire, em_done;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic [1:0] em_k_reg;
    logic [1:0] em_lastk;

    assign out_free = !m_valid_reg || m_ready;
    assign em_fire  = em_valid_reg && out_free;
    assign em_done  = em_fire && (em_k_reg == em_lastk);
    assign s1_fire  = s1_valid_reg && (!em_valid_reg || em_done);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_fire   = s_valid && s_ready;

    // Position counters, advanced at accept
    logic [AW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    pos_flags_t       pos_now;

    always_comb begin
        pos_now.row_end    = EW'(col_count_reg) >= wlast_e;
        pos_now.frame_last = CFG_W'(row_count_reg) >= hlast;
        pos_now.has_out    = (col_count_reg != '0) && (row_count_reg != '0);
        pos_now.c0         = col_count_reg[0];
        pos_now.r0         = row_count_reg[0];
        pos_now.c_is1      = col_count_reg == AW'(1);
        pos_now.r_is1      = row_count_reg == ROW_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_fire) begin
            if (pos_now.row_end) begin
                col_count_reg <= '0;
                row_count_reg <= pos_now.frame_last ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_reg <= col_count_reg + AW'(1);
            end
        end
    end

    // Line buffer: {older, recent} per column, read at accept, written back in stage 1.
    // Consecutive samples always sit at different columns, so the read and the
    // write-back of the same cycle never hit the same entry.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd_reg;
    logic [AW-1:0]      s1_idx_reg;
    pixel_t             s1_raw_reg;
    pos_flags_t         s1_flags_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            line_rd_reg <= line_mem[col_count_reg];
        end
        if (s1_fire) begin
            line_mem[s1_idx_reg] <= {line_rd_reg[PIX_W-1:0], s1_raw_reg};
        end
    end

    // Stage 1 holding register
    assign s1_valid_next = s_fire || (s1_valid_reg && !s1_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_idx_reg   <= col_count_reg;
            s1_raw_reg   <= s_raw_sample;
            s1_flags_reg <= pos_now;
        end
    end

    // 3x3 window: rows older/recent/current, columns c-2/c-1/c
    pixel_t win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]     <= win_reg[k*3 + 1];
                win_reg[k*3 + 1] <= win_reg[k*3 + 2];
            end
            win_reg[2] <= line_rd_reg[2*PIX_W-1:PIX_W];
            win_reg[5] <= line_rd_reg[PIX_W-1:0];
            win_reg[8] <= s1_raw_reg;
        end
    end

    // Emitter: walks the 1, 2 or 4 pixels of one sample, one per cycle while the output register is free
    pos_flags_t em_flags_reg;

    assign em_lastk = {em_flags_reg.row_end & em_flags_reg.frame_last,
                       em_flags_reg.row_end | em_flags_reg.frame_last};
    assign em_valid_next = s1_fire ? s1_flags_reg.has_out : (em_valid_reg && !em_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_k_reg     <= '0;
        end else begin
            em_valid_reg <= em_valid_next;
            if (s1_fire) begin
                em_k_reg <= '0;
            end else if (em_fire) begin
                em_k_reg <= em_k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            em_flags_reg <= s1_flags_reg;
        end
    end

    // Neighborhood selection and interpolation for the current pixel
    logic   bottom, col2, y_odd, x_odd;
    pixel_t t_row [3];
    pixel_t m_row [3];
    pixel_t b_row [3];
    pixel_t t_c, m_l, m_c, m_r, b_c, t_l, t_r, b_l, b_r;
    logic [PIX_W:0]   hs, vs;
    logic [PIX_W+1:0] ds, hv;
    pixel_t red_c, green_c, blue_c;

    always_comb begin
        bottom = em_flags_reg.frame_last & em_k_reg[0];
        col2   = em_flags_reg.frame_last ? em_k_reg[1] : em_k_reg[0];
        y_odd  = bottom ? em_flags_reg.r0 : !em_flags_reg.r0;
        x_odd  = col2 ? em_flags_reg.c0 : !em_flags_reg.c0;

        // Rows, with mirroring at the top and bottom edges
        for (int j = 0; j < 3; j++) begin
            t_row[j] = bottom ? win_reg[3 + j] : (em_flags_reg.r_is1 ? win_reg[6 + j] : win_reg[j]);
            m_row[j] = bottom ? win_reg[6 + j] : win_reg[3 + j];
            b_row[j] = bottom ? win_reg[3 + j] : win_reg[6 + j];
        end

        // Columns, with mirroring at the left and right edges
        t_l = col2 ? t_row[1] : (em_flags_reg.c_is1 ? t_row[2] : t_row[0]);
        t_c = col2 ? t_row[2] : t_row[1];
        t_r = col2 ? t_row[1] : t_row[2];
        m_l = col2 ? m_row[1] : (em_flags_reg.c_is1 ? m_row[2] : m_row[0]);
        m_c = col2 ? m_row[2] : m_row[1];
        m_r = col2 ? m_row[1] : m_row[2];
        b_l = col2 ? b_row[1] : (em_flags_reg.c_is1 ? b_row[2] : b_row[0]);
        b_c = col2 ? b_row[2] : b_row[1];
        b_r = col2 ? b_row[1] : b_row[2];

        hs = {1'b0, m_l} + {1'b0, m_r};
        vs = {1'b0, t_c} + {1'b0, b_c};
        ds = {2'b00, t_l} + {2'b00, t_r} + {2'b00, b_l} + {2'b00, b_r};
        hv = {1'b0, hs} + {1'b0, vs};

        case ({y_odd, x_odd})
            2'b00: begin  // green on a red row
                red_c   = hs[PIX_W:1];
                green_c = m_c;
                blue_c  = vs[PIX_W:1];
            end
            2'b01: begin  // red site
                red_c   = m_c;
                green_c = hv[PIX_W+1:2];
                blue_c  = ds[PIX_W+1:2];
            end
            2'b10: begin  // blue site
                red_c   = ds[PIX_W+1:2];
                green_c = hv[PIX_W+1:2];
                blue_c  = m_c;
            end
            default: begin  // green on a blue row
                red_c   = vs[PIX_W:1];
                green_c = m_c;
                blue_c  = hs[PIX_W:1];
            end
        endcase
    end

    // Output register
    pixel_t m_red_reg, m_green_reg, m_blue_reg;
    logic   m_last_reg, m_frame_end_reg;

    assign m_valid_next = em_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_fire) begin
            m_red_reg       <= red_c;
            m_green_reg     <= green_c;
            m_blue_reg      <= blue_c;
            m_last_reg      <= em_k_reg == em_lastk;
            m_frame_end_reg <= bottom & col2 & em_flags_reg.row_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = m_red_reg;
    assign m_green       = m_green_reg;
    assign m_blue        = m_blue_reg;
    assign m_last_of_run = m_last_reg;
    assign m_frame_end   = m_frame_end_reg;

    // Checks
    `BBD_ASSERT_IMPL(a_no_rw_same_col, aclk, aresetn, s_fire && s1_fire, col_count_reg != s1_idx_reg, "line buffer read and write-back hit the same column")
    `BBD_ASSERT_IMPL(a_em_k_bound, aclk, aresetn, em_valid_reg, em_k_reg <= em_lastk, "emitter index beyond pixel count")
    `BBD_ASSERT_IMPL(a_frame_end_last, aclk, aresetn, m_valid_reg && m_frame_end_reg, m_last_reg, "frame end pixel is not the last of its sample")
    `BBD_ASSERT_IMPL(a_no_window_overrun, aclk, aresetn, em_valid_reg && !em_done, !s1_fire, "window advanced while emitter still busy")

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbd_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 8;

    // One reconstructed pixel as it leaves the block
    typedef struct packed {
        pixel_t red;
        pixel_t green;
        pixel_t blue;
        logic   last_of_run;
        logic   frame_end;
    } rgb_result_t;

    // Directed stimulus: either a frame size to load or one raw sample
    typedef struct {
        bit               is_size;
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;
        pixel_t           raw;
        bit               typed;
        pixel_t           level;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pixel_t               s_raw_sample = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    pixel_t               m_red;
    pixel_t               m_green;
    pixel_t               m_blue;
    logic                 m_last_of_run;
    logic                 m_frame_end;

    bilinear_bayer_demosaic dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_sample  (s_raw_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last_of_run (m_last_of_run),
        .m_frame_end   (m_frame_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the block state
    pixel_t           older_row [LINE_DEPTH];
    pixel_t           recent_row [LINE_DEPTH];
    pixel_t           window [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    rgb_result_t pending_pixels [$];
    int          fail_count = 0;
    bit          no_idle = 1'b0;
    int unsigned ready_stall = 0;
    int unsigned small_items = 0;

    directed_row_t directed_rows [20] = '{
        '{1'b1, 11'd3, 11'd3, 8'h00, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b1, 8'hFF},
        // sizes below the minimum clamp to 3x3
        '{1'b1, 11'd0, 11'd1, 8'h00, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'hFF, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h80, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h7F, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h01, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'hFE, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h55, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'hAA, 1'b0, 8'h00},
        '{1'b0, 11'd0, 11'd0, 8'h00, 1'b0, 8'h00}
    };

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Mostly no gap, some short ones, rarely a long one
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 31);
        if (pick == 0) return $urandom_range(10, 40);
        if (pick < 10) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Bilinear fill of one GRBG position from the 3x3 window
    function automatic rgb_result_t interpolate(int rt, int rm, int rb, int cl, int cm,
                                                int cr, int unsigned y, int unsigned x);
        rgb_result_t px;
        int unsigned ctr, hs, vs, ds;
        ctr = 32'(window[rm*3 + cm]);
        hs  = 32'(window[rm*3 + cl]) + 32'(window[rm*3 + cr]);
        vs  = 32'(window[rt*3 + cm]) + 32'(window[rb*3 + cm]);
        ds  = 32'(window[rt*3 + cl]) + 32'(window[rt*3 + cr])
            + 32'(window[rb*3 + cl]) + 32'(window[rb*3 + cr]);
        px = '0;
        if (y[0] == 1'b0) begin
            if (x[0] == 1'b0) begin
                px.red = pixel_t'(hs >> 1);
                px.green = pixel_t'(ctr);
                px.blue = pixel_t'(vs >> 1);
            end else begin
                px.red = pixel_t'(ctr);
                px.green = pixel_t'((hs + vs) >> 2);
                px.blue = pixel_t'(ds >> 2);
            end
        end else begin
            if (x[0] == 1'b0) begin
                px.red = pixel_t'(ds >> 2);
                px.green = pixel_t'((hs + vs) >> 2);
                px.blue = pixel_t'(ctr);
            end else begin
                px.red = pixel_t'(vs >> 1);
                px.green = pixel_t'(ctr);
                px.blue = pixel_t'(hs >> 1);
            end
        end
        return px;
    endfunction

    // Advance the mirror by one accepted sample and queue the pixels it releases
    function automatic void demosaic_accept(pixel_t raw, bit typed, pixel_t level);
        rgb_result_t released [4];
        int          count, cm, cl, cr, k;
        int unsigned wdt, hgt, c, r, idx, x;
        bit          row_end, frame_last;
        wdt = clamp_size(width_reg, LINE_DEPTH);
        hgt = clamp_size(height_reg, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        idx = (c < LINE_DEPTH) ? c : 0;
        row_end = (c >= wdt - 1);
        frame_last = (r >= hgt - 1);
        count = 0;

        for (k = 0; k < 3; k++) begin
            window[k*3] = window[k*3 + 1];
            window[k*3 + 1] = window[k*3 + 2];
        end
        window[2] = older_row[idx];
        window[5] = recent_row[idx];
        window[8] = raw;
        older_row[idx] = recent_row[idx];
        recent_row[idx] = raw;

        if (c >= 1 && r >= 1) begin
            for (cm = 1; cm <= (row_end ? 2 : 1); cm++) begin
                x  = c + cm - 2;
                cl = (cm == 1 && x == 0) ? 2 : cm - 1;
                cr = (cm == 2) ? 1 : 2;
                // top row mirrors row 1 onto row -1
                released[count] = interpolate((r == 1) ? 2 : 0, 1, 2, cl, cm, cr, r - 1, x);
                count++;
                if (frame_last) begin
                    // bottom row mirrors row H-2 onto row H
                    released[count] = interpolate(1, 2, 1, cl, cm, cr, r, x);
                    released[count].frame_end = (cm == 2);
                    count++;
                end
            end
            released[count-1].last_of_run = 1'b1;
        end

        for (k = 0; k < count; k++) begin
            if (typed) begin
                released[k].red = level;
                released[k].green = level;
                released[k].blue = level;
            end
            pending_pixels.push_back(released[k]);
        end

        if (row_end) begin
            col_pos = 0;
            row_pos = frame_last ? 0 : ((r + 1) & 10'h3FF);
        end else begin
            col_pos = (c + 1) & 13'h1FFF;
        end
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // One raw sample transfer, with an optional idle gap in front
    task automatic send_sample(pixel_t raw, bit typed, pixel_t level);
        int unsigned gap;
        gap = no_idle ? 0 : idle_length();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        demosaic_accept(raw, typed, level);
    endtask

    // Wait for every queued pixel, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        width_reg = w;
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        height_reg = h;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic pixel_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return pixel_t'($urandom_range(0, 255));
    endfunction

    // Pixel output: checking and ready stalls
    always @(posedge aclk) begin : pixel_monitor
        rgb_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel transfer with nothing expected: r=%0d g=%0d b=%0d",
                           m_red, m_green, m_blue);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    compare_field("red", 32'(want.red), 32'(m_red));
                    compare_field("green", 32'(want.green), 32'(m_green));
                    compare_field("blue", 32'(want.blue), 32'(m_blue));
                    compare_field("last_of_run", 32'(want.last_of_run), 32'(m_last_of_run));
                    compare_field("frame_end", 32'(want.frame_end), 32'(m_frame_end));
                end
            end
            if (no_idle) begin
                m_ready <= 1'b1;
            end else if (ready_stall != 0) begin
                m_ready <= 1'b0;
                ready_stall--;
            end else begin
                m_ready <= 1'b1;
                ready_stall = idle_length();
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int i, frames, f;
        int unsigned total;
        logic [CFG_W-1:0] w, h;

        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        col_pos = 0;
        row_pos = 0;
        for (i = 0; i < 9; i++) window[i] = '0;
        for (i = 0; i < LINE_DEPTH; i++) begin
            older_row[i] = '0;
            recent_row[i] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset size: one full 256-wide row and the start of row 1,
        // then shrink to 3x3 inside row 1 and finish the frame
        for (i = 0; i < 256 + 2; i++) send_sample(random_sample(), 1'b0, 8'h00);
        drain();
        write_size(11'd3, 11'd3);
        for (i = 0; i < 4; i++) send_sample(random_sample(), 1'b0, 8'h00);

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_size) begin
                drain();
                write_size(directed_rows[i].width_val, directed_rows[i].height_val);
            end else begin
                send_sample(directed_rows[i].raw, directed_rows[i].typed,
                            directed_rows[i].level);
            end
        end

        // Random frames, some with widths below the minimum
        while (small_items < 100) begin
            w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 3))
                                            : CFG_W'($urandom_range(3, 12));
            h = CFG_W'($urandom_range(3, 8));
            frames = $urandom_range(1, 2);
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            write_size(w, h);
            total = clamp_size(w, LINE_DEPTH) * clamp_size(h, MAX_HEIGHT);
            for (f = 0; f < frames; f++) begin
                for (i = 0; i < total; i++) send_sample(random_sample(), 1'b0, 8'h00);
            end
            small_items += total * frames;
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
